// ===== hdl/smbpec_pkg.sv =====
// smbpec_pkg: shared types, codes and crc-8 helper for the smbus pec framer/checker
// no dependencies; used by every module under hdl/
`default_nettype none

package smbpec_pkg;

  // item action codes
  localparam logic ActStart = 1'b0;
  localparam logic ActByte  = 1'b1;

  // transaction kinds, six and seven are reserved
  typedef enum logic [2:0] {
    OP_SEND_BYTE   = 3'd0,
    OP_RECV_BYTE   = 3'd1,
    OP_WRITE_BYTE  = 3'd2,
    OP_READ_BYTE   = 3'd3,
    OP_BLOCK_WRITE = 3'd4,
    OP_BLOCK_READ  = 3'd5,
    OP_RSVD6       = 3'd6,
    OP_RSVD7       = 3'd7
  } op_e;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_RX     = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  // transaction status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PEC_ERR  = 2'd1,
    ST_OVER_CAP = 2'd2,
    ST_BAD_LEN  = 2'd3
  } status_e;

  // one result item
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  byte_value;
    status_e     status;
    logic [7:0]  reported_count;
    logic        last;
  } result_t;

  // results caused by one input item (one or two)
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } bundle_t;

  // queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  // crc-8, poly x^8+x^2+x+1, msb first
  function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // byte result
  function automatic result_t mk_byte(input kind_e k, input logic [7:0] v, input logic lst);
    result_t r;
    r.kind           = k;
    r.byte_value     = v;
    r.status         = ST_OK;
    r.reported_count = 8'd0;
    r.last           = lst;
    return r;
  endfunction

  // status result, always final
  function automatic result_t mk_status(input status_e s, input logic [7:0] cnt);
    result_t r;
    r.kind           = KIND_STATUS;
    r.byte_value     = 8'd0;
    r.status         = s;
    r.reported_count = cnt;
    r.last           = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/smbus_pec_framer_checker_core.sv =====
// smbus_pec_framer_checker_core: top level, smbus host framer/checker with crc-8 pec
// depends on smbpec_pkg, smbpec_front, smbpec_queue, smbpec_back
//
//   channel   handshake            payload
//   input     push / full          action_i op_kind_i target_i command_i length_i data_byte_i
//   result    empty / pop          kind_o byte_value_o status_o reported_count_o last_o
//   config    cfg_we_i             cfg_data_i (pec enable)
//
// one item accepted per cycle while the bundle queue has room; each item is
// sequenced and its crc folded in the cycle it is accepted
// results leave one per cycle while pop is held, the first passing through the bundle
// queue and then the output register; an item causing two results shows them in turn
// full rises when the four-entry bundle queue fills behind a stalled result side
// reset clears the sequencer, pec enable, the queue and the output register's valid flag
`default_nettype none

module smbus_pec_framer_checker_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_data_i,
  input  wire logic       push,
  output      logic       full,
  input  wire logic       action_i,
  input  wire logic [2:0] op_kind_i,
  input  wire logic [6:0] target_i,
  input  wire logic [7:0] command_i,
  input  wire logic [7:0] length_i,
  input  wire logic [7:0] data_byte_i,
  output      logic       empty,
  input  wire logic       pop,
  output      logic [1:0] kind_o,
  output      logic [7:0] byte_value_o,
  output      logic [1:0] status_o,
  output      logic [7:0] reported_count_o,
  output      logic       last_o
);

  logic                q_push, q_full, q_empty, q_pop;
  smbpec_pkg::bundle_t q_wdata, q_head;
  smbpec_pkg::result_t res;

  assign full = q_full;

  smbpec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .item_vld_i  (push && !q_full),
    .action_i    (action_i),
    .op_kind_i   (op_kind_i),
    .target_i    (target_i),
    .command_i   (command_i),
    .length_i    (length_i),
    .data_byte_i (data_byte_i),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  smbpec_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  smbpec_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res)
  );

  // result fields
  assign kind_o           = res.kind;
  assign byte_value_o     = res.byte_value;
  assign status_o         = res.status;
  assign reported_count_o = res.reported_count;
  assign last_o           = res.last;

endmodule

`default_nettype wire

// ===== hdl/smbpec_front.sv =====
// smbpec_front: accepts items, runs the transaction sequencer and crc, builds result bundles
// depends on smbpec_pkg
`default_nettype none

module smbpec_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_data_i,
  input  wire logic                item_vld_i,
  input  wire logic                action_i,
  input  wire logic [2:0]          op_kind_i,
  input  wire logic [6:0]          target_i,
  input  wire logic [7:0]          command_i,
  input  wire logic [7:0]          length_i,
  input  wire logic [7:0]          data_byte_i,
  output      logic                q_push_o,
  output      smbpec_pkg::bundle_t q_data_o
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_DATA  = 3'd1,
    PH_BLOCK = 3'd2,
    PH_COUNT = 3'd3,
    PH_PEC   = 3'd4
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [2:0] op_q, op_d;
  logic [7:0] len_q, len_d;
  logic [7:0] left_q, left_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] bcnt_q, bcnt_d;
  logic       pec_en_q;

  // crc terms of the start sequence
  logic [7:0] addr_w, addr_r, crc_aw, crc_ar, crc_awc, crc_db;
  assign addr_w  = {target_i, 1'b0};
  assign addr_r  = {target_i, 1'b1};
  assign crc_aw  = smbpec_pkg::crc8_fold(8'h00, addr_w);
  assign crc_ar  = smbpec_pkg::crc8_fold(8'h00, addr_r);
  assign crc_awc = smbpec_pkg::crc8_fold(crc_aw, command_i);
  assign crc_db  = smbpec_pkg::crc8_fold(crc_q, data_byte_i);

  // sequencer and result builder
  always_comb begin
    logic               blk_end;
    smbpec_pkg::bundle_t b;
    logic               has_res;
    blk_end  = (left_q == 8'd1);
    b        = '0;
    has_res  = 1'b0;
    phase_d  = phase_q;
    op_d     = op_q;
    len_d    = len_q;
    left_d   = left_q;
    crc_d    = crc_q;
    bcnt_d   = bcnt_q;

    if (action_i == smbpec_pkg::ActStart) begin
      phase_d = PH_IDLE;
      if (op_kind_i <= smbpec_pkg::OP_BLOCK_READ) begin
        op_d   = op_kind_i;
        len_d  = length_i;
        left_d = 8'd0;
        bcnt_d = 8'd0;
        crc_d  = 8'h00;
        case (op_kind_i)
          smbpec_pkg::OP_SEND_BYTE: begin
            crc_d   = crc_aw;
            phase_d = PH_DATA;
          end
          smbpec_pkg::OP_RECV_BYTE: begin
            crc_d   = crc_ar;
            phase_d = PH_DATA;
          end
          smbpec_pkg::OP_WRITE_BYTE: begin
            crc_d   = crc_awc;
            phase_d = PH_DATA;
            has_res = 1'b1;
            b.r0    = smbpec_pkg::mk_byte(smbpec_pkg::KIND_TX, command_i, 1'b0);
          end
          smbpec_pkg::OP_READ_BYTE: begin
            crc_d   = smbpec_pkg::crc8_fold(crc_awc, addr_r);
            phase_d = PH_DATA;
            has_res = 1'b1;
            b.r0    = smbpec_pkg::mk_byte(smbpec_pkg::KIND_TX, command_i, 1'b0);
          end
          smbpec_pkg::OP_BLOCK_WRITE: begin
            has_res = 1'b1;
            if (length_i == 8'd0) begin
              b.r0 = smbpec_pkg::mk_status(smbpec_pkg::ST_BAD_LEN, 8'd0);
            end else begin
              crc_d   = smbpec_pkg::crc8_fold(crc_awc, length_i);
              left_d  = length_i;
              phase_d = PH_BLOCK;
              b.two   = 1'b1;
              b.r0    = smbpec_pkg::mk_byte(smbpec_pkg::KIND_TX, command_i, 1'b0);
              b.r1    = smbpec_pkg::mk_byte(smbpec_pkg::KIND_TX, length_i, 1'b0);
            end
          end
          default: begin
            has_res = 1'b1;
            if (length_i == 8'd0) begin
              b.r0 = smbpec_pkg::mk_status(smbpec_pkg::ST_BAD_LEN, 8'd0);
            end else begin
              crc_d   = smbpec_pkg::crc8_fold(crc_awc, addr_r);
              phase_d = PH_COUNT;
              b.r0    = smbpec_pkg::mk_byte(smbpec_pkg::KIND_TX, command_i, 1'b0);
            end
          end
        endcase
      end
    end else begin
      case (phase_q)
        PH_DATA: begin
          crc_d   = crc_db;
          has_res = 1'b1;
          if (op_q == smbpec_pkg::OP_SEND_BYTE || op_q == smbpec_pkg::OP_WRITE_BYTE) begin
            phase_d = PH_IDLE;
            b.r0 = smbpec_pkg::mk_byte(smbpec_pkg::KIND_TX, data_byte_i, !pec_en_q);
            b.two = pec_en_q;
            b.r1 = smbpec_pkg::mk_byte(smbpec_pkg::KIND_TX, crc_db, 1'b1);
          end else begin
            b.r0 = smbpec_pkg::mk_byte(smbpec_pkg::KIND_RX, data_byte_i, 1'b0);
            if (pec_en_q) begin
              phase_d = PH_PEC;
            end else begin
              phase_d = PH_IDLE;
              b.two   = 1'b1;
              b.r1    = smbpec_pkg::mk_status(smbpec_pkg::ST_OK, 8'd0);
            end
          end
        end
        PH_BLOCK: begin
          crc_d   = crc_db;
          left_d  = left_q - 8'd1;
          has_res = 1'b1;
          if (op_q == smbpec_pkg::OP_BLOCK_WRITE) begin
            b.r0 = smbpec_pkg::mk_byte(smbpec_pkg::KIND_TX, data_byte_i,
                                       blk_end && !pec_en_q);
            if (blk_end) begin
              phase_d = PH_IDLE;
              b.two   = pec_en_q;
              b.r1    = smbpec_pkg::mk_byte(smbpec_pkg::KIND_TX, crc_db, 1'b1);
            end
          end else begin
            b.r0 = smbpec_pkg::mk_byte(smbpec_pkg::KIND_RX, data_byte_i, 1'b0);
            if (blk_end) begin
              if (pec_en_q) begin
                phase_d = PH_PEC;
              end else begin
                phase_d = PH_IDLE;
                b.two   = 1'b1;
                b.r1    = smbpec_pkg::mk_status(smbpec_pkg::ST_OK, bcnt_q);
              end
            end
          end
        end
        PH_COUNT: begin
          bcnt_d = data_byte_i;
          crc_d  = crc_db;
          if (data_byte_i > len_q) begin
            phase_d = PH_IDLE;
            has_res = 1'b1;
            b.r0    = smbpec_pkg::mk_status(smbpec_pkg::ST_OVER_CAP, data_byte_i);
          end else if (data_byte_i == 8'd0) begin
            if (pec_en_q) begin
              phase_d = PH_PEC;
            end else begin
              phase_d = PH_IDLE;
              has_res = 1'b1;
              b.r0    = smbpec_pkg::mk_status(smbpec_pkg::ST_OK, 8'd0);
            end
          end else begin
            left_d  = data_byte_i;
            phase_d = PH_BLOCK;
          end
        end
        PH_PEC: begin
          phase_d = PH_IDLE;
          has_res = 1'b1;
          b.r0    = smbpec_pkg::mk_status(
                      (data_byte_i == crc_q) ? smbpec_pkg::ST_OK : smbpec_pkg::ST_PEC_ERR,
                      (op_q == smbpec_pkg::OP_BLOCK_READ) ? bcnt_q : 8'd0);
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end

    q_push_o = item_vld_i && has_res;
    q_data_o = b;
  end

  // state registers and pec enable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      op_q     <= smbpec_pkg::OP_SEND_BYTE;
      len_q    <= 8'd0;
      left_q   <= 8'd0;
      crc_q    <= 8'h00;
      bcnt_q   <= 8'd0;
      pec_en_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pec_en_q <= cfg_data_i;
      end
      if (item_vld_i) begin
        phase_q <= phase_d;
        op_q    <= op_d;
        len_q   <= len_d;
        left_q  <= left_d;
        crc_q   <= crc_d;
        bcnt_q  <= bcnt_d;
      end
    end
  end

  // a block phase always has bytes outstanding
  a_block_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BLOCK |-> left_q != 8'd0)
    else $error("block phase with no bytes left");

  // a block read never waits for more bytes than its capacity
  a_block_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BLOCK && op_q == smbpec_pkg::OP_BLOCK_READ) |-> left_q <= len_q)
    else $error("block read count beyond capacity");

  // a start with an unknown op kind leaves the sequencer idle
  a_bad_op_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_vld_i && action_i == smbpec_pkg::ActStart &&
     op_kind_i > smbpec_pkg::OP_BLOCK_READ) |=> phase_q == PH_IDLE)
    else $error("invalid op kind did not abort");

endmodule

`default_nettype wire

// ===== hdl/smbpec_queue.sv =====
// smbpec_queue: short queue of result bundles between front and back
// depends on smbpec_pkg
`default_nettype none

module smbpec_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire smbpec_pkg::bundle_t data_i,
  output      logic                full_o,
  input  wire logic                pop_i,
  output      logic                empty_o,
  output      smbpec_pkg::bundle_t head_o
);

  localparam int unsigned Aw = smbpec_pkg::QAw;

  smbpec_pkg::bundle_t mem_q [smbpec_pkg::QDepth];
  logic [Aw-1:0]       wr_ptr_q, rd_ptr_q;
  logic [Aw:0]         cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == (Aw + 1)'(smbpec_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (Aw + 1)'(do_push) - (Aw + 1)'(do_pop);
    end
  end

  // no bundle is dropped on a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  // fill count matches pointer distance
  a_cnt_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    Aw'(cnt_q) == Aw'(wr_ptr_q - rd_ptr_q))
    else $error("queue count and pointers disagree");

endmodule

`default_nettype wire

// ===== hdl/smbpec_back.sv =====
// smbpec_back: unpacks result bundles into single items behind an output register
// depends on smbpec_pkg
`default_nettype none

module smbpec_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_empty_i,
  input  wire smbpec_pkg::bundle_t q_head_i,
  output      logic                q_pop_o,
  input  wire logic                pop_i,
  output      logic                empty_o,
  output      smbpec_pkg::result_t res_o
);

  logic                out_vld_q, sec_vld_q;
  smbpec_pkg::result_t out_q, sec_q;
  logic                adv;

  // output slot frees when empty or taken
  assign adv     = !out_vld_q || pop_i;
  assign q_pop_o = adv && !sec_vld_q && !q_empty_i;
  assign empty_o = !out_vld_q;
  assign res_o   = out_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      sec_vld_q <= 1'b0;
    end else if (adv) begin
      if (sec_vld_q) begin
        out_vld_q <= 1'b1;
        sec_vld_q <= 1'b0;
      end else if (!q_empty_i) begin
        out_vld_q <= 1'b1;
        sec_vld_q <= q_head_i.two;
      end else begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (sec_vld_q) begin
        out_q <= sec_q;
      end else if (!q_empty_i) begin
        out_q <= q_head_i.r0;
        sec_q <= q_head_i.r1;
      end
    end
  end

  // a pending second item implies the first is still shown
  a_sec_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_vld_q |-> out_vld_q)
    else $error("second result pending with empty output");

  // no new bundle while the second half of the last one waits
  a_no_pop_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_vld_q |-> !q_pop_o)
    else $error("bundle taken while second result pending");

endmodule

`default_nettype wire

// ===== dv/tb_smbus_pec_framer_checker_core.sv =====
// tb_smbus_pec_framer_checker_core: self-checking bench for the smbus pec framer/checker core
// predicts every result item in-line from accepted input items; needs smbpec_pkg and the core
`timescale 1ns / 100ps

module tb_smbus_pec_framer_checker_core;

  localparam int unsigned ItemGoal    = 1550;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned ReportMax   = 10;
  localparam logic [7:0]  PecPoly     = 8'h07;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_DATA,
    FR_BLOCK,
    FR_COUNT,
    FR_PEC
  } frame_phase_e;

  typedef struct {
    logic             action;
    smbpec_pkg::op_e  op;
    logic [6:0]       target;
    logic [7:0]       command;
    logic [7:0]       length;
    logic [7:0]       data;
  } smb_item_t;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       cfg_we_i   = 1'b0;
  logic       cfg_data_i = 1'b0;
  logic       push       = 1'b0;
  logic       full;
  logic       action_i    = 1'b0;
  logic [2:0] op_kind_i   = 3'd0;
  logic [6:0] target_i    = 7'd0;
  logic [7:0] command_i   = 8'd0;
  logic [7:0] length_i    = 8'd0;
  logic [7:0] data_byte_i = 8'd0;
  logic       empty;
  logic       pop = 1'b0;
  logic [1:0] kind_o;
  logic [7:0] byte_value_o;
  logic [1:0] status_o;
  logic [7:0] reported_count_o;
  logic       last_o;

  smbus_pec_framer_checker_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .push             (push),
    .full             (full),
    .action_i         (action_i),
    .op_kind_i        (op_kind_i),
    .target_i         (target_i),
    .command_i        (command_i),
    .length_i         (length_i),
    .data_byte_i      (data_byte_i),
    .empty            (empty),
    .pop              (pop),
    .kind_o           (kind_o),
    .byte_value_o     (byte_value_o),
    .status_o         (status_o),
    .reported_count_o (reported_count_o),
    .last_o           (last_o)
  );

  // clock, 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state, mirrors the framer sequencer
  logic                pec_en;
  frame_phase_e        frame_phase;
  smbpec_pkg::op_e     frame_op;
  logic [7:0]          frame_len;
  logic [7:0]          frame_left;
  logic [7:0]          frame_crc;
  logic [7:0]          frame_count;
  smbpec_pkg::result_t pending_results[$];

  // idling knobs and bookkeeping
  bit          gaps_on   = 1'b0;
  bit          rx_stalls = 1'b0;
  int unsigned max_stall = 4;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_items = 0;
  int unsigned n_live = 0;
  int unsigned n_results = 0;
  int unsigned n_cfg = 0;
  int unsigned n_fail = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};

  // crc-8 over one byte, msb first
  function automatic logic [7:0] pec_fold(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) r = (r << 1) ^ (r[7] ? PecPoly : 8'h00);
    return r;
  endfunction

  function automatic void expect_byte(input smbpec_pkg::kind_e k, input logic [7:0] v,
                                      input logic lst);
    smbpec_pkg::result_t r;
    r.kind           = k;
    r.byte_value     = v;
    r.status         = smbpec_pkg::ST_OK;
    r.reported_count = 8'd0;
    r.last           = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void expect_status(input smbpec_pkg::status_e s, input logic [7:0] cnt);
    smbpec_pkg::result_t r;
    r.kind           = smbpec_pkg::KIND_STATUS;
    r.byte_value     = 8'd0;
    r.status         = s;
    r.reported_count = cnt;
    r.last           = 1'b1;
    pending_results.push_back(r);
  endfunction

  // advance the framer model by one accepted item, queue what it emits
  function automatic void predict_smbus_results(input smb_item_t it);
    logic [7:0] addr_w;
    logic [7:0] addr_r;
    logic       done;
    addr_w = {it.target, 1'b0};
    addr_r = {it.target, 1'b1};
    if (it.action == smbpec_pkg::ActStart) begin
      frame_phase = FR_IDLE;
      if (it.op > smbpec_pkg::OP_BLOCK_READ) return;
      frame_op    = it.op;
      frame_len   = it.length;
      frame_left  = 8'd0;
      frame_count = 8'd0;
      frame_crc   = 8'd0;
      case (it.op)
        smbpec_pkg::OP_SEND_BYTE: begin
          frame_crc   = pec_fold(8'd0, addr_w);
          frame_phase = FR_DATA;
        end
        smbpec_pkg::OP_RECV_BYTE: begin
          frame_crc   = pec_fold(8'd0, addr_r);
          frame_phase = FR_DATA;
        end
        smbpec_pkg::OP_WRITE_BYTE: begin
          frame_crc   = pec_fold(pec_fold(8'd0, addr_w), it.command);
          frame_phase = FR_DATA;
          expect_byte(smbpec_pkg::KIND_TX, it.command, 1'b0);
        end
        smbpec_pkg::OP_READ_BYTE: begin
          frame_crc   = pec_fold(pec_fold(pec_fold(8'd0, addr_w), it.command), addr_r);
          frame_phase = FR_DATA;
          expect_byte(smbpec_pkg::KIND_TX, it.command, 1'b0);
        end
        smbpec_pkg::OP_BLOCK_WRITE: begin
          if (it.length == 8'd0) begin
            expect_status(smbpec_pkg::ST_BAD_LEN, 8'd0);
          end else begin
            frame_crc   = pec_fold(pec_fold(pec_fold(8'd0, addr_w), it.command), it.length);
            frame_left  = it.length;
            frame_phase = FR_BLOCK;
            expect_byte(smbpec_pkg::KIND_TX, it.command, 1'b0);
            expect_byte(smbpec_pkg::KIND_TX, it.length, 1'b0);
          end
        end
        default: begin
          if (it.length == 8'd0) begin
            expect_status(smbpec_pkg::ST_BAD_LEN, 8'd0);
          end else begin
            frame_crc   = pec_fold(pec_fold(pec_fold(8'd0, addr_w), it.command), addr_r);
            frame_phase = FR_COUNT;
            expect_byte(smbpec_pkg::KIND_TX, it.command, 1'b0);
          end
        end
      endcase
      return;
    end

    case (frame_phase)
      FR_DATA: begin
        frame_crc = pec_fold(frame_crc, it.data);
        if (frame_op == smbpec_pkg::OP_SEND_BYTE || frame_op == smbpec_pkg::OP_WRITE_BYTE) begin
          frame_phase = FR_IDLE;
          expect_byte(smbpec_pkg::KIND_TX, it.data, !pec_en);
          if (pec_en) expect_byte(smbpec_pkg::KIND_TX, frame_crc, 1'b1);
        end else begin
          expect_byte(smbpec_pkg::KIND_RX, it.data, 1'b0);
          if (pec_en) begin
            frame_phase = FR_PEC;
          end else begin
            frame_phase = FR_IDLE;
            expect_status(smbpec_pkg::ST_OK, 8'd0);
          end
        end
      end
      FR_BLOCK: begin
        frame_crc  = pec_fold(frame_crc, it.data);
        frame_left = frame_left - 8'd1;
        done       = (frame_left == 8'd0);
        if (frame_op == smbpec_pkg::OP_BLOCK_WRITE) begin
          expect_byte(smbpec_pkg::KIND_TX, it.data, done && !pec_en);
          if (done) begin
            frame_phase = FR_IDLE;
            if (pec_en) expect_byte(smbpec_pkg::KIND_TX, frame_crc, 1'b1);
          end
        end else begin
          expect_byte(smbpec_pkg::KIND_RX, it.data, 1'b0);
          if (done) begin
            if (pec_en) begin
              frame_phase = FR_PEC;
            end else begin
              frame_phase = FR_IDLE;
              expect_status(smbpec_pkg::ST_OK, frame_count);
            end
          end
        end
      end
      FR_COUNT: begin
        frame_count = it.data;
        frame_crc   = pec_fold(frame_crc, it.data);
        if (it.data > frame_len) begin
          frame_phase = FR_IDLE;
          expect_status(smbpec_pkg::ST_OVER_CAP, it.data);
        end else if (it.data == 8'd0) begin
          if (pec_en) begin
            frame_phase = FR_PEC;
          end else begin
            frame_phase = FR_IDLE;
            expect_status(smbpec_pkg::ST_OK, 8'd0);
          end
        end else begin
          frame_left  = it.data;
          frame_phase = FR_BLOCK;
        end
      end
      FR_PEC: begin
        frame_phase = FR_IDLE;
        expect_status((it.data == frame_crc) ? smbpec_pkg::ST_OK : smbpec_pkg::ST_PEC_ERR,
                      (frame_op == smbpec_pkg::OP_BLOCK_READ) ? frame_count : 8'd0);
      end
      default: frame_phase = FR_IDLE;
    endcase
  endfunction

  function automatic smb_item_t mk_start(input smbpec_pkg::op_e op, input logic [6:0] tgt,
                                         input logic [7:0] cmd, input logic [7:0] len);
    smb_item_t it;
    it.action  = smbpec_pkg::ActStart;
    it.op      = op;
    it.target  = tgt;
    it.command = cmd;
    it.length  = len;
    it.data    = 8'($urandom);
    return it;
  endfunction

  // data byte, the start-only fields carry noise
  function automatic smb_item_t mk_data(input logic [7:0] db);
    smb_item_t it;
    it.action  = smbpec_pkg::ActByte;
    it.op      = smbpec_pkg::op_e'($urandom_range(0, 7));
    it.target  = 7'($urandom);
    it.command = 8'($urandom);
    it.length  = 8'($urandom);
    it.data    = db;
    return it;
  endfunction

  // sender: bursts separated by random gaps when gaps are on, returns at the accepting edge
  task automatic send_item(input smb_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = 0;
      if (gaps_on)
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push        <= 1'b1;
    action_i    <= it.action;
    op_kind_i   <= it.op;
    target_i    <= it.target;
    command_i   <= it.command;
    length_i    <= it.length;
    data_byte_i <= it.data;
    do @(posedge clk_i); while (full);
    n_items++;
    if (it.action == smbpec_pkg::ActStart ? (it.op <= smbpec_pkg::OP_BLOCK_READ)
                                          : (frame_phase != FR_IDLE))
      n_live++;
    predict_smbus_results(it);
  endtask

  // pec enable write, only once the pipeline has drained
  task automatic set_pec(input logic en);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= en;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pec_en = en;
    n_cfg++;
  endtask

  function automatic logic [7:0] pick_block_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 8'd0;
    if (r < 75) return 8'($urandom_range(1, 4));
    if (r < 95) return 8'($urandom_range(5, 16));
    if (r < 99) return 8'($urandom_range(17, 64));
    return 8'hFF;
  endfunction

  // block read count: mostly within capacity, some zero, some oversize
  function automatic logic [7:0] pick_count(input logic [7:0] cap);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 24 && cap != 8'hFF) return 8'($urandom_range(cap + 1, 255));
    if (r < 28) return 8'($urandom_range(1, cap));
    return 8'($urandom_range(1, (cap < 8) ? cap : 8));
  endfunction

  // one well-formed transaction with random content, now and then toggled or cut short
  task automatic run_transaction();
    smbpec_pkg::op_e op;
    logic [7:0]      len;
    op  = smbpec_pkg::op_e'($urandom_range(smbpec_pkg::OP_SEND_BYTE,
                                           smbpec_pkg::OP_BLOCK_READ));
    len = (op >= smbpec_pkg::OP_BLOCK_WRITE) ? pick_block_length() : 8'($urandom);
    send_item(mk_start(op, 7'($urandom), 8'($urandom), len));
    while (frame_phase != FR_IDLE) begin
      if ($urandom_range(0, 49) == 0) set_pec(~pec_en);
      if ($urandom_range(0, 79) == 0) break;
      case (frame_phase)
        FR_COUNT: send_item(mk_data(pick_count(frame_len)));
        FR_PEC: begin
          if ($urandom_range(0, 9) == 0)
            send_item(mk_data(frame_crc ^ 8'($urandom_range(1, 255))));
          else
            send_item(mk_data(frame_crc));
        end
        default: send_item(mk_data(8'($urandom)));
      endcase
    end
    // surplus byte after the end
    if ($urandom_range(0, 15) == 0) send_item(mk_data(8'($urandom)));
  endtask

  // random mix of transactions and noise until enough items went in
  task automatic traffic_until(input int unsigned goal, input bit vary_idling);
    int unsigned pick;
    while (n_items < goal) begin
      pick = $urandom_range(0, 99);
      if (vary_idling && pick < 3) begin
        gaps_on   = 1'($urandom_range(0, 1));
        rx_stalls = 1'($urandom_range(0, 1));
      end
      if (pick >= 96) set_pec(1'($urandom_range(0, 1)));
      if (pick < 80) begin
        run_transaction();
      end else if (pick < 87) begin
        send_item(mk_data(8'($urandom)));
      end else if (pick < 93) begin
        send_item(mk_start(pick[0] ? smbpec_pkg::OP_RSVD7 : smbpec_pkg::OP_RSVD6,
                           7'($urandom), 8'($urandom), 8'($urandom)));
      end else begin
        // start with no data of its own; the items that follow may abort it
        send_item(mk_start(smbpec_pkg::op_e'($urandom_range(0, 5)), 7'($urandom),
                           8'($urandom), 8'($urandom_range(1, 255))));
      end
    end
  endtask

  // every op but read byte with pec off, zero length, oversize and zero count, stray and bad op
  task automatic test_framing_pec_off();
    set_pec(1'b0);
    send_item(mk_start(smbpec_pkg::OP_SEND_BYTE, 7'h7F, 8'h00, 8'hFF));
    send_item(mk_data(8'hFF));
    send_item(mk_start(smbpec_pkg::OP_RECV_BYTE, 7'h00, 8'hFF, 8'h00));
    send_item(mk_data(8'h00));
    send_item(mk_start(smbpec_pkg::OP_WRITE_BYTE, 7'h55, 8'hFF, 8'h80));
    send_item(mk_data(8'hA5));
    send_item(mk_start(smbpec_pkg::OP_BLOCK_WRITE, 7'h12, 8'h34, 8'h00));
    send_item(mk_start(smbpec_pkg::OP_BLOCK_READ, 7'h13, 8'hC3, 8'h02));
    send_item(mk_data(8'h03));
    send_item(mk_start(smbpec_pkg::OP_BLOCK_READ, 7'h15, 8'h3C, 8'hFF));
    send_item(mk_data(8'h00));
    send_item(mk_start(smbpec_pkg::OP_RSVD6, 7'h2A, 8'h80, 8'h01));
    send_item(mk_data(8'h44));
  endtask

  // pec on: good and bad pec, zero count, start while busy
  task automatic test_checking_pec_on();
    set_pec(1'b1);
    send_item(mk_start(smbpec_pkg::OP_READ_BYTE, 7'h2A, 8'h01, 8'h7F));
    send_item(mk_data(8'h80));
    send_item(mk_data(frame_crc));
    send_item(mk_start(smbpec_pkg::OP_BLOCK_READ, 7'h40, 8'h99, 8'h04));
    send_item(mk_data(8'h00));
    send_item(mk_data(frame_crc ^ 8'h01));
    send_item(mk_start(smbpec_pkg::OP_SEND_BYTE, 7'h01, 8'h10, 8'h20));
    send_item(mk_start(smbpec_pkg::OP_BLOCK_WRITE, 7'h11, 8'h80, 8'h01));
    send_item(mk_data(8'h5A));
  endtask

  // register flipped between the items of one transaction
  task automatic test_pec_toggle_mid_transaction();
    send_item(mk_start(smbpec_pkg::OP_RECV_BYTE, 7'h3C, 8'h00, 8'h00));
    set_pec(1'b0);
    send_item(mk_data(8'hC3));
    send_item(mk_start(smbpec_pkg::OP_WRITE_BYTE, 7'h63, 8'h7E, 8'h00));
    set_pec(1'b1);
    send_item(mk_data(8'h81));
  endtask

  task automatic test_random_traffic();
    gaps_on   = 1'b1;
    rx_stalls = 1'b1;
    max_stall = 6;
    traffic_until(ItemGoal - 400, 1'b1);
  endtask

  // sender never idles, receiver stalls long so the queue fills
  task automatic test_full_backpressure();
    gaps_on   = 1'b0;
    rx_stalls = 1'b1;
    max_stall = 24;
    traffic_until(ItemGoal, 1'b0);
  endtask

  // receiver: own stall pattern of random runs
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      pop        <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
      pop        <= 1'b0;
      stall_left <= $urandom_range(0, max_stall);
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic report_failure(input string why, input smbpec_pkg::result_t want,
                                input smbpec_pkg::result_t got);
    n_fail++;
    if (n_fail <= ReportMax) begin
      $display("%s at %0t: expected kind %0d byte %02h status %0d count %02h last %0d",
               why, $time, want.kind, want.byte_value, want.status, want.reported_count,
               want.last);
      $display("  got kind %0d byte %02h status %0d count %02h last %0d",
               got.kind, got.byte_value, got.status, got.reported_count, got.last);
    end
  endtask

  // result checker, oldest expectation first
  always @(posedge clk_i) begin
    smbpec_pkg::result_t got;
    smbpec_pkg::result_t want;
    if (rst_ni && pop && !empty) begin
      got.kind           = smbpec_pkg::kind_e'(kind_o);
      got.byte_value     = byte_value_o;
      got.status         = smbpec_pkg::status_e'(status_o);
      got.reported_count = reported_count_o;
      got.last           = last_o;
      n_results++;
      if (got.kind == smbpec_pkg::KIND_STATUS) status_seen[got.status]++;
      if (pending_results.size() == 0) begin
        report_failure("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.byte_value !== want.byte_value ||
            got.status !== want.status || got.reported_count !== want.reported_count ||
            got.last !== want.last)
          report_failure("result mismatch", want, got);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pec_en      = 1'b0;
    frame_phase = FR_IDLE;
    frame_op    = smbpec_pkg::OP_SEND_BYTE;
    frame_len   = 8'd0;
    frame_left  = 8'd0;
    frame_crc   = 8'd0;
    frame_count = 8'd0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_framing_pec_off();
    test_checking_pec_on();
    test_pec_toggle_mid_transaction();
    test_random_traffic();
    test_full_backpressure();

    // drain, then give stray results time to show up
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("sent %0d items (%0d live), checked %0d results, %0d pec enable writes",
             n_items, n_live, n_results, n_cfg);
    $display("statuses ok %0d, pec error %0d, over capacity %0d, bad length %0d, failures %0d",
             status_seen[smbpec_pkg::ST_OK], status_seen[smbpec_pkg::ST_PEC_ERR],
             status_seen[smbpec_pkg::ST_OVER_CAP], status_seen[smbpec_pkg::ST_BAD_LEN],
             n_fail);
    if (n_fail == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
